// ----- hw/rtl/krt_pkg.sv -----
package krt_pkg;

    localparam int DEPTH   = 128;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 7;
    localparam int DATA_W  = 2 * VAL_W;

    typedef enum logic [1:0] {
        MODE_INSERT    = 2'd0,
        MODE_LOOKUP    = 2'd1,
        MODE_ADD_QTY   = 2'd2,
        MODE_ADD_PRICE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_UPDATE,
        S_DONE
    } state_t;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        logic signed [VAL_W-1:0] r;
        begin
            s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
            if (s[VAL_W] != s[VAL_W-1])
            begin
                r = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
            end
            else
            begin
                r = s[VAL_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- hw/rtl/keyed_record_table_unit.sv -----
// Flow: on a key hit a request passes S_SCAN, S_FETCH, S_UPDATE and S_DONE; on a miss
// it goes from S_SCAN to S_DONE, and an insert into a full table goes straight to S_DONE;
// the key scan reads one key memory entry per cycle.
// Handshake: one request at a time; in_ready rises with out_valid, so a new request is
// taken only after the previous result is issued, which can wait on out_ready.
// Reset: rst_n, asynchronous, active low, empties the table; memory contents are kept.
module keyed_record_table_unit
    import krt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              mode,
    input  logic signed [VAL_W-1:0] record_key,
    input  logic signed [VAL_W-1:0] quantity_value,
    input  logic signed [VAL_W-1:0] price_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic [SLOT_W-1:0]       slot,
    output logic signed [VAL_W-1:0] quantity_out,
    output logic signed [VAL_W-1:0] price_out
);

    state_t state_reg, state_next;

    mode_t                   mode_reg, mode_next;
    logic [VAL_W-1:0]        key_reg, key_next;
    logic signed [VAL_W-1:0] qv_reg, qv_next;
    logic signed [VAL_W-1:0] pv_reg, pv_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;

    status_t                 res_status_reg, res_status_next;
    logic [IDX_W-1:0]        res_slot_reg, res_slot_next;
    logic signed [VAL_W-1:0] res_q_reg, res_q_next;
    logic signed [VAL_W-1:0] res_p_reg, res_p_next;

    logic                    out_valid_reg, out_valid_next;
    status_t                 status_reg, status_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic signed [VAL_W-1:0] q_out_reg, q_out_next;
    logic signed [VAL_W-1:0] p_out_reg, p_out_next;

    logic                    in_fire;
    logic                    issue_en;
    logic                    hit;
    logic                    miss;
    logic                    out_free;

    logic                    key_wr_en;
    logic [IDX_W-1:0]        key_wr_addr;
    logic [VAL_W-1:0]        key_rd_data;
    logic                    data_wr_en;
    logic [IDX_W-1:0]        data_wr_addr;
    logic [DATA_W-1:0]       data_wr_data;
    logic [DATA_W-1:0]       data_rd_data;
    logic signed [VAL_W-1:0] rd_q;
    logic signed [VAL_W-1:0] rd_p;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign issue_en = (state_reg == S_SCAN) && (issue_reg < cnt_reg);
    assign hit      = (state_reg == S_SCAN) && cmp_vld_reg && (key_rd_data == key_reg);
    assign miss     = (state_reg == S_SCAN) && !cmp_vld_reg && !issue_en;
    assign out_free = !out_valid_reg || out_ready;
    assign rd_q     = data_rd_data[DATA_W-1:VAL_W];
    assign rd_p     = data_rd_data[VAL_W-1:0];

    krt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_reg),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (key_rd_data)
    );

    krt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data),
        .rd_addr (idx_reg),
        .rd_data (data_rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if ((mode_t'(mode) == MODE_INSERT) && (cnt_reg == CNT_W'(DEPTH)))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_FETCH;
                end
                else if (miss)
                begin
                    state_next = S_DONE;
                end
            end
            S_FETCH:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next       = mode_reg;
        key_next        = key_reg;
        qv_next         = qv_reg;
        pv_next         = pv_reg;
        cnt_next        = cnt_reg;
        issue_next      = issue_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_q_next      = res_q_reg;
        res_p_next      = res_p_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        slot_next       = slot_reg;
        q_out_next      = q_out_reg;
        p_out_next      = p_out_reg;
        key_wr_en       = 1'b0;
        key_wr_addr     = cnt_reg[IDX_W-1:0];
        data_wr_en      = 1'b0;
        data_wr_addr    = cnt_reg[IDX_W-1:0];
        data_wr_data    = {qv_reg, pv_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next       = mode_t'(mode);
                    key_next        = record_key;
                    qv_next         = quantity_value;
                    pv_next         = price_value;
                    issue_next      = '0;
                    res_status_next = ST_FULL;
                    res_slot_next   = '0;
                    res_q_next      = '0;
                    res_p_next      = '0;
                end
            end
            S_SCAN:
            begin
                // Keep one read in flight; compare the key read last cycle.
                if (hit)
                begin
                    idx_next = cmp_idx_reg;
                end
                else if (miss)
                begin
                    if (mode_reg == MODE_INSERT)
                    begin
                        key_wr_en       = 1'b1;
                        data_wr_en      = 1'b1;
                        cnt_next        = cnt_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_slot_next   = cnt_reg[IDX_W-1:0];
                        res_q_next      = qv_reg;
                        res_p_next      = pv_reg;
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                        res_q_next      = '0;
                        res_p_next      = '0;
                    end
                end
                else if (issue_en)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
            end
            S_UPDATE:
            begin
                res_slot_next   = idx_reg;
                res_q_next      = rd_q;
                res_p_next      = rd_p;
                res_status_next = ST_OK;
                data_wr_addr    = idx_reg;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        res_status_next = ST_DUPLICATE;
                    end
                    MODE_ADD_QTY:
                    begin
                        res_q_next   = sat_add(rd_q, qv_reg);
                        data_wr_en   = 1'b1;
                        data_wr_data = {sat_add(rd_q, qv_reg), rd_p};
                    end
                    MODE_ADD_PRICE:
                    begin
                        res_p_next   = sat_add(rd_p, pv_reg);
                        data_wr_en   = 1'b1;
                        data_wr_data = {rd_q, sat_add(rd_p, pv_reg)};
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    slot_next      = SLOT_W'(res_slot_reg);
                    q_out_next     = res_q_reg;
                    p_out_next     = res_p_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        qv_reg         <= qv_next;
        pv_reg         <= pv_next;
        issue_reg      <= issue_next;
        cmp_idx_reg    <= cmp_idx_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_q_reg      <= res_q_next;
        res_p_reg      <= res_p_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        q_out_reg      <= q_out_next;
        p_out_reg      <= p_out_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign quantity_out = q_out_reg;
    assign price_out    = p_out_reg;

endmodule

// ----- hw/rtl/krt_ram.sv -----
module krt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
